// ===== src/lswc_pkg.sv =====
package lswc_pkg;

    // Result status codes.
    localparam logic [1:0] STATUS_VISIBLE  = 2'd0;
    localparam logic [1:0] STATUS_PARALLEL = 2'd1;
    localparam logic [1:0] STATUS_REJECT   = 2'd2;

    // Register map: register i sits at byte address 4*i.
    localparam int ADDR_BITS = 4;
    localparam int APB_DATA_BITS = 32;
    localparam logic [1:0] REG_WINDOW_LEFT   = 2'd0;
    localparam logic [1:0] REG_WINDOW_RIGHT  = 2'd1;
    localparam logic [1:0] REG_WINDOW_BOTTOM = 2'd2;
    localparam logic [1:0] REG_WINDOW_TOP    = 2'd3;

    // Reset values of the window registers.
    localparam int WINDOW_LEFT_RESET   = 0;
    localparam int WINDOW_RIGHT_RESET  = 639;
    localparam int WINDOW_BOTTOM_RESET = 0;
    localparam int WINDOW_TOP_RESET    = 479;

    // Number of coordinate lanes in the back end.
    localparam int LANES = 4;

endpackage

// ===== src/lswc_front.sv =====
module lswc_front #(
    parameter int  COORD_BITS = 16,
    parameter type item_t     = logic
) (
    input  logic signed [COORD_BITS-1:0] window_left,
    input  logic signed [COORD_BITS-1:0] window_right,
    input  logic signed [COORD_BITS-1:0] window_bottom,
    input  logic signed [COORD_BITS-1:0] window_top,
    input  logic signed [COORD_BITS-1:0] start_x,
    input  logic signed [COORD_BITS-1:0] start_y,
    input  logic signed [COORD_BITS-1:0] end_x,
    input  logic signed [COORD_BITS-1:0] end_y,
    output item_t                        item
);

    localparam int W = COORD_BITS;
    localparam logic signed [W:0] ONE_N = 1;
    localparam logic [W-1:0] ONE_D = 1;

    logic signed [W:0] sx, sy, ex, ey, dx, dy;
    logic signed [W:0] lft, rgt, bot, top_w;

    // Classify the segment: deltas, parallel test and the entry and exit
    // fractions per axis, each kept as a numerator over a positive denominator.
    always_comb begin
        sx    = (W+1)'(start_x);
        sy    = (W+1)'(start_y);
        ex    = (W+1)'(end_x);
        ey    = (W+1)'(end_y);
        lft   = (W+1)'(window_left);
        rgt   = (W+1)'(window_right);
        bot   = (W+1)'(window_bottom);
        top_w = (W+1)'(window_top);
        dx    = ex - sx;
        dy    = ey - sy;

        item      = '0;
        item.sx   = start_x;
        item.sy   = start_y;
        item.negx = dx[W];
        item.negy = dy[W];
        item.adx  = dx[W] ? W'(-dx) : W'(dx);
        item.ady  = dy[W] ? W'(-dy) : W'(dy);
        item.par  = ((dx == '0) && ((sx < lft) || (sx > rgt))) ||
                    ((dy == '0) && ((sy < bot) || (sy > top_w)));

        // Left and right edges.
        if (dx == '0) begin
            item.enx_n = '0;
            item.enx_d = ONE_D;
            item.exx_n = ONE_N;
            item.exx_d = ONE_D;
        end else if (dx[W]) begin
            item.enx_n = sx - rgt;
            item.enx_d = W'(-dx);
            item.exx_n = sx - lft;
            item.exx_d = W'(-dx);
        end else begin
            item.enx_n = lft - sx;
            item.enx_d = W'(dx);
            item.exx_n = rgt - sx;
            item.exx_d = W'(dx);
        end

        // Bottom and top edges.
        if (dy == '0) begin
            item.eny_n = '0;
            item.eny_d = ONE_D;
            item.exy_n = ONE_N;
            item.exy_d = ONE_D;
        end else if (dy[W]) begin
            item.eny_n = sy - top_w;
            item.eny_d = W'(-dy);
            item.exy_n = sy - bot;
            item.exy_d = W'(-dy);
        end else begin
            item.eny_n = bot - sy;
            item.eny_d = W'(dy);
            item.exy_n = top_w - sy;
            item.exy_d = W'(dy);
        end
    end

endmodule

// ===== src/lswc_queue.sv =====
module lswc_queue #(
    parameter int  DEPTH  = 4,
    parameter type item_t = logic
) (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  push,
    input  item_t push_item,
    output logic  full,
    input  logic  pop,
    output logic  out_valid,
    output item_t out_item
);

    localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_BITS = $clog2(DEPTH + 1);
    localparam logic [PTR_BITS-1:0] LAST = PTR_BITS'(DEPTH - 1);
    localparam logic [CNT_BITS-1:0] FULL_COUNT = CNT_BITS'(DEPTH);

    item_t               mem_reg [0:DEPTH-1];
    logic [PTR_BITS-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_BITS-1:0] count_reg;
    logic                do_push, do_pop;

    assign full      = (count_reg == FULL_COUNT);
    assign out_valid = (count_reg != '0);
    assign out_item  = mem_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && out_valid;

    // Storage.
    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// ===== src/lswc_back.sv =====
module lswc_back #(
    parameter int  COORD_BITS = 16,
    parameter type item_t     = logic
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    in_valid,
    input  item_t                   in_item,
    output logic                    pop,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [1:0]              out_status,
    output logic [COORD_BITS-1:0]   out_start_x,
    output logic [COORD_BITS-1:0]   out_start_y,
    output logic [COORD_BITS-1:0]   out_end_x,
    output logic [COORD_BITS-1:0]   out_end_y
);

    localparam int W = COORD_BITS;
    localparam int L = lswc_pkg::LANES;
    localparam logic signed [W:0] ONE_N = 1;
    localparam logic [W-1:0] ONE_D = 1;

    logic adv;

    // The whole pipeline advances unless a finished result is held.
    assign adv = !out_valid || out_ready;
    assign pop = in_valid && adv;

    // Stage 1: cross products that rank the two entry and two exit fractions.
    logic                    s1_valid_reg;
    item_t                   s1_item_reg;
    logic signed [2*W+1:0]   s1_pex_reg, s1_pey_reg, s1_qx_reg, s1_qy_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (adv) begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s1_item_reg <= in_item;
            s1_pex_reg  <= in_item.enx_n * $signed({1'b0, in_item.eny_d});
            s1_pey_reg  <= in_item.eny_n * $signed({1'b0, in_item.enx_d});
            s1_qx_reg   <= in_item.exx_n * $signed({1'b0, in_item.exy_d});
            s1_qy_reg   <= in_item.exy_n * $signed({1'b0, in_item.exx_d});
        end
    end

    // Stage 2: pick the latest entry, raised to at least 0, and the earliest exit, cut to at most 1.
    logic                  s2_valid_reg;
    item_t                 s2_item_reg;
    logic signed [W:0]     s2_u1n_reg, s2_u2n_reg, u1n_next, u2n_next;
    logic [W-1:0]          s2_u1d_reg, s2_u2d_reg, u1d_next, u2d_next;

    always_comb begin
        if (s1_pex_reg >= s1_pey_reg) begin
            u1n_next = s1_item_reg.enx_n;
            u1d_next = s1_item_reg.enx_d;
        end else begin
            u1n_next = s1_item_reg.eny_n;
            u1d_next = s1_item_reg.eny_d;
        end
        if (u1n_next[W]) begin
            u1n_next = '0;
            u1d_next = ONE_D;
        end
        if (s1_qx_reg <= s1_qy_reg) begin
            u2n_next = s1_item_reg.exx_n;
            u2d_next = s1_item_reg.exx_d;
        end else begin
            u2n_next = s1_item_reg.exy_n;
            u2d_next = s1_item_reg.exy_d;
        end
        if (u2n_next > $signed({1'b0, u2d_next})) begin
            u2n_next = ONE_N;
            u2d_next = ONE_D;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
        end else if (adv) begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s2_item_reg <= s1_item_reg;
            s2_u1n_reg  <= u1n_next;
            s2_u1d_reg  <= u1d_next;
            s2_u2n_reg  <= u2n_next;
            s2_u2d_reg  <= u2d_next;
        end
    end

    // Stage 3: entry-versus-exit cross products and the four dividends.
    logic                  s3_valid_reg;
    logic                  s3_par_reg;
    logic signed [2*W+1:0] s3_c1_reg, s3_c2_reg;
    logic [2*W-1:0]        s3_num_reg [0:L-1];
    logic [W-1:0]          s3_den_reg [0:L-1];
    logic [W-1:0]          s3_org_reg [0:L-1];
    logic                  s3_neg_reg [0:L-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s3_valid_reg <= 1'b0;
        end else if (adv) begin
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s3_par_reg    <= s2_item_reg.par;
            s3_c1_reg     <= s2_u1n_reg * $signed({1'b0, s2_u2d_reg});
            s3_c2_reg     <= s2_u2n_reg * $signed({1'b0, s2_u1d_reg});
            s3_num_reg[0] <= s2_u1n_reg[W-1:0] * s2_item_reg.adx;
            s3_num_reg[1] <= s2_u1n_reg[W-1:0] * s2_item_reg.ady;
            s3_num_reg[2] <= s2_u2n_reg[W-1:0] * s2_item_reg.adx;
            s3_num_reg[3] <= s2_u2n_reg[W-1:0] * s2_item_reg.ady;
            s3_den_reg[0] <= s2_u1d_reg;
            s3_den_reg[1] <= s2_u1d_reg;
            s3_den_reg[2] <= s2_u2d_reg;
            s3_den_reg[3] <= s2_u2d_reg;
            s3_org_reg[0] <= s2_item_reg.sx;
            s3_org_reg[1] <= s2_item_reg.sy;
            s3_org_reg[2] <= s2_item_reg.sx;
            s3_org_reg[3] <= s2_item_reg.sy;
            s3_neg_reg[0] <= s2_item_reg.negx;
            s3_neg_reg[1] <= s2_item_reg.negy;
            s3_neg_reg[2] <= s2_item_reg.negx;
            s3_neg_reg[3] <= s2_item_reg.negy;
        end
    end

    // Divider pipeline: stage 0 holds the status and the initial partial
    // remainders, each later stage resolves one quotient bit per lane.
    logic             dv_valid_reg [0:W];
    logic [1:0]       dv_stat_reg  [0:W];
    logic [W-1:0]     dv_rem_reg   [0:W][0:L-1];
    logic [W-1:0]     dv_low_reg   [0:W][0:L-1];
    logic [W-1:0]     dv_quo_reg   [0:W][0:L-1];
    logic [W-1:0]     dv_den_reg   [0:W][0:L-1];
    logic [W-1:0]     dv_org_reg   [0:W][0:L-1];
    logic             dv_neg_reg   [0:W][0:L-1];
    logic [1:0]       stat_next;

    always_comb begin
        if (s3_par_reg) begin
            stat_next = lswc_pkg::STATUS_PARALLEL;
        end else if (s3_c1_reg > s3_c2_reg) begin
            stat_next = lswc_pkg::STATUS_REJECT;
        end else begin
            stat_next = lswc_pkg::STATUS_VISIBLE;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dv_valid_reg[0] <= 1'b0;
        end else if (adv) begin
            dv_valid_reg[0] <= s3_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            dv_stat_reg[0] <= stat_next;
            for (int i = 0; i < L; i++) begin
                dv_rem_reg[0][i] <= s3_num_reg[i][2*W-1:W];
                dv_low_reg[0][i] <= s3_num_reg[i][W-1:0];
                dv_quo_reg[0][i] <= '0;
                dv_den_reg[0][i] <= s3_den_reg[i];
                dv_org_reg[0][i] <= s3_org_reg[i];
                dv_neg_reg[0][i] <= s3_neg_reg[i];
            end
        end
    end

    for (genvar k = 0; k < W; k++) begin : g_div
        logic [W:0]   shift_next [0:L-1];
        logic         ge_next    [0:L-1];
        logic [W-1:0] rem_next   [0:L-1];

        // One restoring division step per lane.
        always_comb begin
            for (int i = 0; i < L; i++) begin
                shift_next[i] = {dv_rem_reg[k][i], dv_low_reg[k][i][W-1]};
                ge_next[i]    = (shift_next[i] >= {1'b0, dv_den_reg[k][i]});
                rem_next[i]   = ge_next[i] ? W'(shift_next[i] - {1'b0, dv_den_reg[k][i]})
                                           : W'(shift_next[i]);
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                dv_valid_reg[k+1] <= 1'b0;
            end else if (adv) begin
                dv_valid_reg[k+1] <= dv_valid_reg[k];
            end
        end

        always_ff @(posedge aclk) begin
            if (adv) begin
                dv_stat_reg[k+1] <= dv_stat_reg[k];
                for (int i = 0; i < L; i++) begin
                    dv_rem_reg[k+1][i] <= rem_next[i];
                    dv_low_reg[k+1][i] <= {dv_low_reg[k][i][W-2:0], 1'b0};
                    dv_quo_reg[k+1][i] <= {dv_quo_reg[k][i][W-2:0], ge_next[i]};
                    dv_den_reg[k+1][i] <= dv_den_reg[k][i];
                    dv_org_reg[k+1][i] <= dv_org_reg[k][i];
                    dv_neg_reg[k+1][i] <= dv_neg_reg[k][i];
                end
            end
        end
    end

    // Final stage: apply the offset along the segment, truncate toward zero, zero a non-visible result.
    logic [1:0]        out_stat_reg;
    logic [W-1:0]      out_coord_reg [0:L-1];
    logic              out_valid_reg;
    logic signed [W:0] sum_next   [0:L-1];
    logic [W-1:0]      coord_next [0:L-1];

    always_comb begin
        for (int i = 0; i < L; i++) begin
            if (dv_neg_reg[W][i]) begin
                sum_next[i] = $signed((W+1)'($signed(dv_org_reg[W][i])))
                            - $signed({1'b0, dv_quo_reg[W][i]});
                if ((dv_rem_reg[W][i] != '0) && (sum_next[i] > 0)) begin
                    sum_next[i] = sum_next[i] - $signed((W+1)'(1));
                end
            end else begin
                sum_next[i] = $signed((W+1)'($signed(dv_org_reg[W][i])))
                            + $signed({1'b0, dv_quo_reg[W][i]});
                if ((dv_rem_reg[W][i] != '0) && sum_next[i][W]) begin
                    sum_next[i] = sum_next[i] + $signed((W+1)'(1));
                end
            end
            coord_next[i] = (dv_stat_reg[W] == lswc_pkg::STATUS_VISIBLE)
                          ? sum_next[i][W-1:0] : '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (adv) begin
            out_valid_reg <= dv_valid_reg[W];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            out_stat_reg <= dv_stat_reg[W];
            for (int i = 0; i < L; i++) begin
                out_coord_reg[i] <= coord_next[i];
            end
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_status  = out_stat_reg;
    assign out_start_x = out_coord_reg[0];
    assign out_start_y = out_coord_reg[1];
    assign out_end_x   = out_coord_reg[2];
    assign out_end_y   = out_coord_reg[3];

endmodule

// ===== src/line_segment_window_clip_unit.sv =====
// Throughput: one segment per cycle unless the result side stalls; the divider is unrolled
// one quotient bit per stage. A QUEUE_DEPTH-entry queue (four by default) sits between the
// classifying front and the clipping back end.
// Reset (aresetn, synchronous, active low) empties the queue and pipeline and loads
// the window registers with left 0, right 639, bottom 0, top 479.
module line_segment_window_clip_unit #(
    parameter int COORD_BITS  = 16,
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // Input stream.
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // Fields from bit 0: start_x, start_y, end_x, end_y, zero padding.
    input  logic [((4*COORD_BITS+7)/8)*8-1:0]    s_tdata,
    // Result stream.
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // Fields from bit 0: clipped_start_x, clipped_start_y, clipped_end_x,
    // clipped_end_y, zero padding.
    output logic [((4*COORD_BITS+7)/8)*8-1:0]    m_tdata,
    // Fields from bit 0: clip_status.
    output logic [1:0]                           m_tuser,
    // Register port.
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [lswc_pkg::ADDR_BITS-1:0]       paddr,
    input  logic [lswc_pkg::APB_DATA_BITS-1:0]   pwdata,
    output logic [lswc_pkg::APB_DATA_BITS-1:0]   prdata,
    output logic                                 pready
);

    localparam int W = COORD_BITS;
    localparam int DATA_BITS = ((4*W+7)/8)*8;

    typedef struct packed {
        logic              par;
        logic [W-1:0]      sx;
        logic [W-1:0]      sy;
        logic [W-1:0]      adx;
        logic [W-1:0]      ady;
        logic              negx;
        logic              negy;
        logic signed [W:0] enx_n;
        logic [W-1:0]      enx_d;
        logic signed [W:0] eny_n;
        logic [W-1:0]      eny_d;
        logic signed [W:0] exx_n;
        logic [W-1:0]      exx_d;
        logic signed [W:0] exy_n;
        logic [W-1:0]      exy_d;
    } lswc_item_t;

    logic signed [W-1:0] window_left_reg, window_right_reg;
    logic signed [W-1:0] window_bottom_reg, window_top_reg;
    logic                cfg_write;
    lswc_item_t          front_item, queue_item;
    logic                queue_full, queue_valid, queue_pop, push;
    logic [W-1:0]        res_sx, res_sy, res_ex, res_ey;

    // Register port: writes complete in the access phase, reads are immediate.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_left_reg   <= W'(lswc_pkg::WINDOW_LEFT_RESET);
            window_right_reg  <= W'(lswc_pkg::WINDOW_RIGHT_RESET);
            window_bottom_reg <= W'(lswc_pkg::WINDOW_BOTTOM_RESET);
            window_top_reg    <= W'(lswc_pkg::WINDOW_TOP_RESET);
        end else if (cfg_write) begin
            case (paddr[3:2])
                lswc_pkg::REG_WINDOW_LEFT:   window_left_reg   <= pwdata[W-1:0];
                lswc_pkg::REG_WINDOW_RIGHT:  window_right_reg  <= pwdata[W-1:0];
                lswc_pkg::REG_WINDOW_BOTTOM: window_bottom_reg <= pwdata[W-1:0];
                lswc_pkg::REG_WINDOW_TOP:    window_top_reg    <= pwdata[W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            lswc_pkg::REG_WINDOW_LEFT:   prdata = 32'(window_left_reg);
            lswc_pkg::REG_WINDOW_RIGHT:  prdata = 32'(window_right_reg);
            lswc_pkg::REG_WINDOW_BOTTOM: prdata = 32'(window_bottom_reg);
            lswc_pkg::REG_WINDOW_TOP:    prdata = 32'(window_top_reg);
            default:                     prdata = '0;
        endcase
    end

    // Front end: classify each segment as it is accepted.
    lswc_front #(
        .COORD_BITS (W),
        .item_t     (lswc_item_t)
    ) u_front (
        .window_left   (window_left_reg),
        .window_right  (window_right_reg),
        .window_bottom (window_bottom_reg),
        .window_top    (window_top_reg),
        .start_x       (s_tdata[W-1:0]),
        .start_y       (s_tdata[2*W-1:W]),
        .end_x         (s_tdata[3*W-1:2*W]),
        .end_y         (s_tdata[4*W-1:3*W]),
        .item          (front_item)
    );

    assign s_tready = !queue_full;
    assign push     = s_tvalid && s_tready;

    lswc_queue #(
        .DEPTH  (QUEUE_DEPTH),
        .item_t (lswc_item_t)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_item (front_item),
        .full      (queue_full),
        .pop       (queue_pop),
        .out_valid (queue_valid),
        .out_item  (queue_item)
    );

    // Back end: fraction selection, rejection and endpoint division.
    lswc_back #(
        .COORD_BITS (W),
        .item_t     (lswc_item_t)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (queue_valid),
        .in_item     (queue_item),
        .pop         (queue_pop),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_status  (m_tuser),
        .out_start_x (res_sx),
        .out_start_y (res_sy),
        .out_end_x   (res_ex),
        .out_end_y   (res_ey)
    );

    assign m_tdata = DATA_BITS'({res_ey, res_ex, res_sy, res_sx});

endmodule

// ===== src/lswc_checker.sv =====
module lswc_checker #(
    parameter int COORD_BITS = 16
) (
    input logic                                aclk,
    input logic                                aresetn,
    input logic                                m_tvalid,
    input logic                                m_tready,
    input logic [((4*COORD_BITS+7)/8)*8-1:0]   m_tdata,
    input logic [1:0]                          m_tuser,
    input logic                                psel,
    input logic                                penable,
    input logic                                pwrite,
    input logic [lswc_pkg::ADDR_BITS-1:0]      paddr,
    input logic [lswc_pkg::APB_DATA_BITS-1:0]  pwdata,
    input logic [lswc_pkg::APB_DATA_BITS-1:0]  prdata,
    input logic                                pready
);

    localparam int W = COORD_BITS;

    // A reset cycle leaves no result on the output.
    a_reset_clears: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // A stalled result keeps its value.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    // A segment that is not visible carries zero coordinates.
    a_reject_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser != lswc_pkg::STATUS_VISIBLE) |-> (m_tdata[4*W-1:0] == '0))
        else $error("rejected segment has nonzero coordinates");

    // A register reads back the value just written to it.
    a_readback: assert property (@(posedge aclk) disable iff (!aresetn)
        (psel && penable && pwrite && pready) ##1 (paddr[3:2] == $past(paddr[3:2]))
        |-> (prdata[W-1:0] == $past(pwdata[W-1:0])))
        else $error("register readback mismatch");

endmodule

bind line_segment_window_clip_unit lswc_checker #(
    .COORD_BITS (COORD_BITS)
) u_lswc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
);

// ===== tb/line_segment_window_clip_checker.sv =====
`timescale 1ns / 100ps

module line_segment_window_clip_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [63:0] s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [63:0] m_tdata,
    input  logic [1:0]  m_tuser,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [lswc_pkg::ADDR_BITS-1:0]     paddr,
    input  logic [lswc_pkg::APB_DATA_BITS-1:0] pwdata,
    input  logic        pready,
    output int          pending,
    output int          failures
);

    typedef struct packed {
        logic [1:0]         status;
        logic signed [15:0] sx;
        logic signed [15:0] sy;
        logic signed [15:0] ex;
        logic signed [15:0] ey;
    } clip_result_t;

    clip_result_t clip_queue[$];
    logic signed [15:0] win_left, win_right, win_bottom, win_top;

    // Sign of a/b - c/d with b and d positive.
    function automatic int frac_order(longint a, longint b, longint c, longint d);
        longint diff;
        diff = a * d - c * b;
        return (diff > 0) ? 1 : ((diff < 0) ? -1 : 0);
    endfunction

    // Point at fraction n/d along the segment, truncated toward zero.
    function automatic logic [15:0] point_at(longint origin, longint delta,
                                             longint n, longint d);
        longint v;
        v = (origin * d + n * delta) / d;
        return v[15:0];
    endfunction

    function automatic clip_result_t clip_segment(logic [63:0] seg);
        clip_result_t r;
        longint sx, sy, ex, ey, dx, dy;
        longint p[4];
        longint q[4];
        longint in_n, in_d, out_n, out_d;
        sx = $signed(seg[15:0]);
        sy = $signed(seg[31:16]);
        ex = $signed(seg[47:32]);
        ey = $signed(seg[63:48]);
        dx = ex - sx;
        dy = ey - sy;
        p[0] = -dx; q[0] = sx - longint'(win_left);
        p[1] = dx;  q[1] = longint'(win_right) - sx;
        p[2] = -dy; q[2] = sy - longint'(win_bottom);
        p[3] = dy;  q[3] = longint'(win_top) - sy;
        in_n = 0; in_d = 1; out_n = 1; out_d = 1;
        r = '0;
        // A segment parallel to an edge and outside it is dropped at once.
        for (int i = 0; i < 4; i++) begin
            if (p[i] == 0 && q[i] < 0) begin
                r.status = lswc_pkg::STATUS_PARALLEL;
                return r;
            end
        end
        // Entry fraction is the latest entering edge, exit the earliest leaving edge.
        for (int i = 0; i < 4; i++) begin
            if (p[i] < 0) begin
                if (frac_order(-q[i], -p[i], in_n, in_d) > 0) begin
                    in_n = -q[i];
                    in_d = -p[i];
                end
            end else if (p[i] > 0) begin
                if (frac_order(q[i], p[i], out_n, out_d) < 0) begin
                    out_n = q[i];
                    out_d = p[i];
                end
            end
        end
        if (frac_order(in_n, in_d, out_n, out_d) > 0) begin
            r.status = lswc_pkg::STATUS_REJECT;
            return r;
        end
        r.status = lswc_pkg::STATUS_VISIBLE;
        r.sx = point_at(sx, dx, in_n, in_d);
        r.sy = point_at(sy, dy, in_n, in_d);
        r.ex = point_at(sx, dx, out_n, out_d);
        r.ey = point_at(sy, dy, out_n, out_d);
        return r;
    endfunction

    assign pending = clip_queue.size();

    always @(posedge aclk) begin
        clip_result_t want;
        clip_result_t got;
        if (!aresetn) begin
            win_left   <= 16'(lswc_pkg::WINDOW_LEFT_RESET);
            win_right  <= 16'(lswc_pkg::WINDOW_RIGHT_RESET);
            win_bottom <= 16'(lswc_pkg::WINDOW_BOTTOM_RESET);
            win_top    <= 16'(lswc_pkg::WINDOW_TOP_RESET);
            clip_queue.delete();
            failures = 0;
        end else begin
            // Register writes take effect after this edge.
            if (psel && penable && pwrite && pready) begin
                case (paddr[3:2])
                    lswc_pkg::REG_WINDOW_LEFT:   win_left   <= pwdata[15:0];
                    lswc_pkg::REG_WINDOW_RIGHT:  win_right  <= pwdata[15:0];
                    lswc_pkg::REG_WINDOW_BOTTOM: win_bottom <= pwdata[15:0];
                    lswc_pkg::REG_WINDOW_TOP:    win_top    <= pwdata[15:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                clip_queue.push_back(clip_segment(s_tdata));
            // Compare each result transaction with the oldest expectation.
            if (m_tvalid && m_tready) begin
                got = {m_tuser, m_tdata[15:0], m_tdata[31:16],
                       m_tdata[47:32], m_tdata[63:48]};
                if (clip_queue.size() == 0) begin
                    failures++;
                    if (failures <= 10)
                        $display("%0t: unexpected result status=%0d data=%h",
                                 $realtime, m_tuser, m_tdata);
                end else begin
                    want = clip_queue.pop_front();
                    if (got !== want) begin
                        failures++;
                        if (failures <= 10)
                            $display({"%0t: mismatch expected st=%0d (%0d,%0d)-(%0d,%0d)",
                                      " got st=%0d (%0d,%0d)-(%0d,%0d)"}, $realtime,
                                     want.status, want.sx, want.sy, want.ex, want.ey,
                                     got.status, got.sx, got.sy, got.ex, got.ey);
                    end
                end
            end
        end
    end

endmodule

// ===== tb/line_segment_window_clip_unit_test.sv =====
`timescale 1ns / 100ps

module line_segment_window_clip_unit_test;

    localparam int DRAIN_CYCLES = 40;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [63:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [lswc_pkg::ADDR_BITS-1:0]     paddr = '0;
    logic [lswc_pkg::APB_DATA_BITS-1:0] pwdata = '0;
    logic [lswc_pkg::APB_DATA_BITS-1:0] prdata;
    logic        pready;
    int          pending;
    int          failures;
    int          burst_left = 0;

    always #4 aclk = ~aclk;

    line_segment_window_clip_unit dut (.*);

    line_segment_window_clip_checker checker_i (
        .aclk, .aresetn, .s_tvalid, .s_tready, .s_tdata, .m_tvalid, .m_tready,
        .m_tdata, .m_tuser, .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
        .pending, .failures
    );

    // Register write: setup cycle, then access cycle.
    task automatic write_reg(logic [1:0] index, logic [15:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {index, 2'b00};
        pwdata  <= {16'(0), value};
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_window(logic [15:0] l, logic [15:0] r,
                              logic [15:0] b, logic [15:0] t);
        wait (pending == 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        write_reg(lswc_pkg::REG_WINDOW_LEFT, l);
        write_reg(lswc_pkg::REG_WINDOW_RIGHT, r);
        write_reg(lswc_pkg::REG_WINDOW_BOTTOM, b);
        write_reg(lswc_pkg::REG_WINDOW_TOP, t);
    endtask

    // Offer one segment; the sender drops valid only between bursts.
    task automatic send_segment(logic [15:0] sx, logic [15:0] sy,
                                logic [15:0] ex, logic [15:0] ey);
        s_tvalid <= 1'b1;
        s_tdata  <= {ey, ex, sy, sx};
        do @(posedge aclk); while (!s_tready);
        if (burst_left == 0) begin
            burst_left = $urandom_range(20, 1);
            if ($urandom_range(3, 0) != 0) begin
                s_tvalid <= 1'b0;
                repeat ($urandom_range(6, 1)) @(posedge aclk);
            end
        end else begin
            burst_left--;
        end
    endtask

    // Coordinate mostly near a window span, sometimes anywhere.
    function automatic logic [15:0] pick_coord(int lo, int hi);
        int span;
        if ($urandom_range(4, 0) == 0)
            return 16'($urandom);
        span = hi - lo;
        if (span < 0) span = -span;
        return 16'(lo - span / 4 - 4 + int'($urandom_range(span + span / 2 + 8, 0)));
    endfunction

    task automatic random_segments(int count, int l, int r, int b, int t);
        logic [15:0] sx, sy, ex, ey;
        for (int i = 0; i < count; i++) begin
            sx = pick_coord(l, r);
            sy = pick_coord(b, t);
            ex = pick_coord(l, r);
            ey = pick_coord(b, t);
            case ($urandom_range(9, 0))
                0: ex = sx;
                1: ey = sy;
                2: begin ex = sx; ey = sy; end
                default: ;
            endcase
            send_segment(sx, sy, ex, ey);
        end
        s_tvalid <= 1'b0;
        @(posedge aclk);
    endtask

    // Receiver: changing stall patterns plus one long hold-off while the
    // first batch of segments is still being offered.
    initial begin
        int mode;
        int cycle;
        cycle = 0;
        wait (aresetn);
        forever begin
            mode = $urandom_range(2, 0);
            for (int k = 0; k < 64; k++) begin
                @(posedge aclk);
                cycle++;
                if (cycle >= 40 && cycle < 240)
                    m_tready <= 1'b0;
                else if (mode == 0)
                    m_tready <= 1'b1;
                else if (mode == 1)
                    m_tready <= ($urandom_range(1, 0) == 1);
                else
                    m_tready <= ($urandom_range(4, 0) == 0);
            end
        end
    end

    initial begin
        #3000000;
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed cases against the reset window.
        send_segment(16'd10, 16'd10, 16'd600, 16'd400);
        send_segment(-16'sd50, 16'd100, 16'd50, 16'd200);
        send_segment(-16'sd100, -16'sd100, 16'd800, 16'd700);
        send_segment(16'd700, 16'd100, 16'd10, 16'd100);
        send_segment(16'd100, 16'd20, 16'd100, 16'd900);
        send_segment(16'd100, 16'd600, 16'd500, 16'd600);
        send_segment(-16'sd5, 16'd10, -16'sd5, 16'd300);
        send_segment(16'd320, 16'd240, 16'd320, 16'd240);
        send_segment(16'd900, 16'd240, 16'd900, 16'd240);
        send_segment(-16'sd100, 16'd400, 16'd100, 16'd700);
        send_segment(16'h8000, 16'h8000, 16'h7fff, 16'h7fff);
        send_segment(16'h7fff, 16'h8000, 16'h8000, 16'h7fff);
        send_segment(16'h8000, 16'h7fff, 16'h7fff, 16'h8000);
        send_segment(16'd0, 16'd0, 16'd0, 16'd0);
        send_segment(16'd639, 16'd479, 16'd0, 16'd0);
        send_segment(16'hffff, 16'hffff, 16'hffff, 16'hffff);
        send_segment(16'd1, 16'd2, 16'd638, 16'd5);
        s_tvalid <= 1'b0;
        @(posedge aclk);
        random_segments(100, 0, 639, 0, 479);

        // Widest window, then the narrowest possible one.
        set_window(16'h8000, 16'h7fff, 16'h8000, 16'h7fff);
        random_segments(100, -32768, 32767, -32768, 32767);
        set_window(16'd7, 16'd7, -16'sd3, -16'sd3);
        random_segments(80, 7, 7, -3, -3);

        // Inverted window yields only parallel or rejected results.
        set_window(16'd500, -16'sd500, 16'd300, -16'sd300);
        random_segments(80, -500, 500, -300, 300);

        // Windows hugging the negative and positive extremes, then a small one near the origin.
        set_window(16'h8000, -16'sd32000, 16'h8000, -16'sd31000);
        random_segments(80, -32768, -32000, -32768, -31000);
        set_window(16'd32000, 16'h7fff, 16'd100, 16'h7fff);
        random_segments(80, 32000, 32767, 100, 32767);
        set_window(-16'sd37, 16'd91, -16'sd13, 16'd55);
        random_segments(110, -37, 91, -13, 55);

        wait (pending == 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (failures == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
